/* hdl/cds_pkg.sv */
package cds_pkg;

    // Fixed field widths of the configuration port and the data path.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int HW_W       = 2;
    localparam int SAMPLE_W   = 32;
    localparam int PROD_W     = 2 * SAMPLE_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_BASE   = 3'd1;

    localparam logic [HW_W-1:0] HALF_WIDTH_RESET = 2'd1;

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 32'sh8000_0000;

    // Per-cycle controls shared by every cell of the window chain.
    typedef struct packed {
        logic shift;   // take the neighbor's sample
        logic load;    // register the product of the held sample
    } t_cell_ctl;

endpackage

/* hdl/cds_cell.sv */
module cds_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cds_pkg::t_cell_ctl                    i_ctl,
    input  logic signed [cds_pkg::SAMPLE_W-1:0]   i_sample_in,
    input  logic signed [cds_pkg::SAMPLE_W-1:0]   i_coef,
    output logic signed [cds_pkg::SAMPLE_W-1:0]   o_sample,
    output logic signed [cds_pkg::PROD_W-1:0]     o_prod
);

    logic signed [cds_pkg::SAMPLE_W-1:0] r_sample;
    logic signed [cds_pkg::PROD_W-1:0]   r_prod;
    logic signed [cds_pkg::PROD_W-1:0]   n_prod;

    // Operands are sign extended in the 64-bit context: a 32x32 multiply.
    assign n_prod = r_sample * i_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_ctl.shift) begin
            r_sample <= i_sample_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= n_prod;
        end
    end

    assign o_sample = r_sample;
    assign o_prod   = r_prod;

endmodule

/* hdl/cds_add_stage.sv */
module cds_add_stage #(
    parameter int N_IN = 7,
    parameter int IN_W = 64
) (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic signed [IN_W-1:0] i_val [N_IN],
    output logic signed [IN_W:0]   o_val [(N_IN + 1) / 2]
);

    localparam int N_OUT = (N_IN + 1) / 2;

    logic signed [IN_W:0] r_sum [N_OUT];
    logic signed [IN_W:0] n_sum [N_OUT];

    // Pairwise sums; an odd last element passes on sign extended.
    always_comb begin
        for (int j = 0; j < N_OUT; j++) begin
            if (2 * j + 1 < N_IN) begin
                n_sum[j] = (IN_W + 1)'(i_val[2 * j]) + (IN_W + 1)'(i_val[2 * j + 1]);
            end else begin
                n_sum[j] = (IN_W + 1)'(i_val[2 * j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= n_sum;
        end
    end

    assign o_val = r_sum;

endmodule

/* hdl/central_difference_stencil_core.sv */
// Streaming central-difference stencil. Each accepted word is one field sample
// along the differentiated axis, ghost cells included, in signed Q16.16 (the
// fraction width is FRAC_BITS). Raise i_line_first with the first sample of a
// line; the window then refills and no result appears until the line holds
// 2*half_width+1 samples, after which every sample yields one result word: the
// sum of tap_coeff_i times the i-th oldest window sample, rounded to nearest
// (ties toward plus infinity) and clamped to the 32-bit range, with
// o_saturated set when clamping happened. Configuration (index 0 half_width,
// indexes 1 to 7 tap_coeff_0 to tap_coeff_6) must be written while the block
// is idle. A half width of zero acts as one, and one above (MAX_TAPS-1)/2 is
// clamped. The block takes one word per clock while o_stall is low: the window
// is a chain of MAX_TAPS cells, each with its own 32x32 multiplier, followed
// by a two-level registered adder tree and a round-and-saturate stage, so a
// result passes the product, adder and output registers after its sample is
// accepted, and the rate is bounded only by the output stall.
module central_difference_stencil_core #(
    parameter int MAX_TAPS  = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [cds_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [cds_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // Sample channel.
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [cds_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                  i_line_first,
    // Result channel.
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [cds_pkg::SAMPLE_W-1:0]   o_derivative,
    output logic                                  o_saturated
);

    localparam int FILL_W = $clog2(MAX_TAPS + 1);
    localparam int HMAX   = (MAX_TAPS - 1) / 2;
    localparam int P1     = (MAX_TAPS + 1) / 2;
    localparam int P2     = (P1 + 1) / 2;
    localparam int SUM_W  = cds_pkg::PROD_W + 3;

    localparam logic [FILL_W-1:0]         FILL_FULL = FILL_W'(MAX_TAPS);
    localparam logic [cds_pkg::HW_W-1:0]  HW_LIMIT  = cds_pkg::HW_W'(HMAX);
    localparam logic signed [SUM_W-1:0]   ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [cds_pkg::HW_W-1:0]            r_half_width;
    logic signed [cds_pkg::SAMPLE_W-1:0] r_tap [MAX_TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= cds_pkg::HALF_WIDTH_RESET;
            for (int j = 0; j < MAX_TAPS; j++) begin
                r_tap[j] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cds_pkg::CFG_HALF_WIDTH) begin
                r_half_width <= i_cfg_data[cds_pkg::HW_W-1:0];
            end
            // Taps past MAX_TAPS are never used, so writes to them are dropped.
            for (int j = 0; j < MAX_TAPS; j++) begin
                if (i_cfg_idx == cds_pkg::CFG_TAP_BASE + cds_pkg::CFG_IDX_W'(j)) begin
                    r_tap[j] <= i_cfg_data;
                end
            end
        end
    end

    // Effective half width and tap count.
    logic [cds_pkg::HW_W-1:0] w_hw_eff;
    logic [FILL_W-1:0]        w_taps;

    always_comb begin
        if (r_half_width == '0) begin
            w_hw_eff = cds_pkg::HW_W'(1);
        end else if (r_half_width > HW_LIMIT) begin
            w_hw_eff = HW_LIMIT;
        end else begin
            w_hw_eff = r_half_width;
        end
    end

    assign w_taps = FILL_W'({w_hw_eff, 1'b1});

    // Cell k holds the k-th newest sample, which takes tap number taps-1-k.
    // Cells beyond the current tap count get a zero weight.
    logic signed [cds_pkg::SAMPLE_W-1:0] w_coef [MAX_TAPS];

    always_comb begin
        for (int k = 0; k < MAX_TAPS; k++) begin
            w_coef[k] = '0;
            for (int j = 0; j < MAX_TAPS; j++) begin
                if (j + k == int'(w_taps) - 1) begin
                    w_coef[k] = r_tap[j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Stage a is the window itself, b the products,
    // c and d the adder tree, o the output register. A stage is free when
    // it is empty or its contents move on in this cycle.
    // ------------------------------------------------------------------
    logic r_va, r_vb, r_vc, r_vd, r_vo;
    logic w_free_a, w_free_b, w_free_c, w_free_d, w_free_o;
    logic w_accept;
    logic w_result;

    assign w_free_o = !r_vo || !i_stall;
    assign w_free_d = !r_vd || w_free_o;
    assign w_free_c = !r_vc || w_free_d;
    assign w_free_b = !r_vb || w_free_c;
    assign w_free_a = !r_va || w_free_b;

    assign o_stall  = !w_free_a;
    assign w_accept = i_valid && w_free_a;

    // Fill count of the current line, saturating at the window depth.
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;

    always_comb begin
        if (i_line_first) begin
            n_fill = FILL_W'(1);
        end else if (r_fill == FILL_FULL) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    assign w_result = n_fill >= w_taps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_va   <= 1'b0;
            r_vb   <= 1'b0;
            r_vc   <= 1'b0;
            r_vd   <= 1'b0;
            r_vo   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill <= n_fill;
            end
            // A sample that completes no stencil shifts the window only.
            if (w_free_a) begin
                r_va <= w_accept && w_result;
            end
            if (w_free_b) begin
                r_vb <= r_va;
            end
            if (w_free_c) begin
                r_vc <= r_vb;
            end
            if (w_free_d) begin
                r_vd <= r_vc;
            end
            if (w_free_o) begin
                r_vo <= r_vd;
            end
        end
    end

    // ------------------------------------------------------------------
    // Window chain: each cell hands its sample to the next one on accept
    // and multiplies its held sample by its weight when stage b loads.
    // ------------------------------------------------------------------
    cds_pkg::t_cell_ctl                  w_ctl;
    logic signed [cds_pkg::SAMPLE_W-1:0] w_sample [MAX_TAPS];
    logic signed [cds_pkg::PROD_W-1:0]   w_prod [MAX_TAPS];

    assign w_ctl.shift = w_accept;
    assign w_ctl.load  = w_free_b;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        logic signed [cds_pkg::SAMPLE_W-1:0] w_in;

        if (k == 0) begin : g_head
            assign w_in = i_sample;
        end else begin : g_link
            assign w_in = w_sample[k - 1];
        end

        cds_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_sample_in (w_in),
            .i_coef      (w_coef[k]),
            .o_sample    (w_sample[k]),
            .o_prod      (w_prod[k])
        );
    end

    // ------------------------------------------------------------------
    // Adder tree, two registered levels.
    // ------------------------------------------------------------------
    logic signed [cds_pkg::PROD_W:0]   w_sum1 [P1];
    logic signed [cds_pkg::PROD_W+1:0] w_sum2 [P2];

    cds_add_stage #(
        .N_IN (MAX_TAPS),
        .IN_W (cds_pkg::PROD_W)
    ) u_add1 (
        .i_clk  (i_clk),
        .i_load (w_free_c),
        .i_val  (w_prod),
        .o_val  (w_sum1)
    );

    cds_add_stage #(
        .N_IN (P1),
        .IN_W (cds_pkg::PROD_W + 1)
    ) u_add2 (
        .i_clk  (i_clk),
        .i_load (w_free_d),
        .i_val  (w_sum1),
        .o_val  (w_sum2)
    );

    // ------------------------------------------------------------------
    // Final add, round to nearest and saturate to 32 bits.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]             w_total;
    logic signed [SUM_W-1:0]             w_shifted;
    logic [SUM_W-32:0]                   w_upper;
    logic                                w_sat;
    logic signed [cds_pkg::SAMPLE_W-1:0] w_clamped;

    always_comb begin
        w_total = ROUND_HALF;
        for (int j = 0; j < P2; j++) begin
            w_total = w_total + SUM_W'(w_sum2[j]);
        end
    end

    assign w_shifted = w_total >>> FRAC_BITS;
    // In range exactly when every bit from bit 31 upward matches the sign.
    assign w_upper   = w_shifted[SUM_W-1:31];
    assign w_sat     = !((&w_upper) || !(|w_upper));

    always_comb begin
        if (!w_sat) begin
            w_clamped = w_shifted[cds_pkg::SAMPLE_W-1:0];
        end else if (w_shifted[SUM_W-1]) begin
            w_clamped = cds_pkg::OUT_MIN;
        end else begin
            w_clamped = cds_pkg::OUT_MAX;
        end
    end

    logic signed [cds_pkg::SAMPLE_W-1:0] r_derivative;
    logic                                r_saturated;

    always_ff @(posedge i_clk) begin
        if (w_free_o) begin
            r_derivative <= w_clamped;
            r_saturated  <= w_sat;
        end
    end

    assign o_valid      = r_vo;
    assign o_derivative = r_derivative;
    assign o_saturated  = r_saturated;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond window depth");

    a_result_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_result) |=> r_va)
        else $error("completed stencil did not enter the pipeline");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vo) |-> $past(r_vd))
        else $error("result word appeared without a source stage");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_derivative == cds_pkg::OUT_MAX || o_derivative == cds_pkg::OUT_MIN))
        else $error("saturated result is not a range limit");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

// Checks the streaming central-difference stencil against a predictor kept in
// the testbench. Each sample word that the block accepts is pushed through
// the predictor, and any derivative word it yields waits in a queue. Every
// derivative word leaving the block is compared with the oldest queued one.
// A short directed table comes first: reset state, exact ties, both
// saturation limits, the widest accumulator case, line restarts, and width
// changes in the middle of a line. Random phases follow, each with its own
// width and idling pattern and, mostly, its own tap set.
module testbench;

    localparam int PERIOD      = 8;
    localparam int NUM_TAPS    = 7;
    localparam int FRAC        = 16;
    // Idle wait after the last expected word, so the pipe can drain.
    localparam int PIPE_SETTLE = 10;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 200;
    localparam int NUM_PHASES  = 20;
    localparam int PHASE_WORDS = 46;

    localparam logic [31:0] Q_ONE      = 32'h0001_0000;
    localparam logic [31:0] Q_HALF     = 32'h0000_8000;
    localparam logic [31:0] Q_HALF_NEG = 32'hFFFF_8000;

    typedef struct {
        logic signed [cds_pkg::SAMPLE_W-1:0] derivative;
        logic                                saturated;
    } t_deriv;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    // One row of the directed table: either a sample word or a register write.
    typedef struct {
        t_row_kind                     kind;
        logic [cds_pkg::CFG_IDX_W-1:0] idx;
        logic [31:0]                   value;
        logic                          line_first;
        logic                          typed;
        t_deriv                        result;
    } t_stim_row;

    logic                                i_clk        = 1'b0;
    logic                                i_rst_n      = 1'b0;
    logic                                i_cfg_we     = 1'b0;
    logic [cds_pkg::CFG_IDX_W-1:0]       i_cfg_idx    = cds_pkg::CFG_HALF_WIDTH;
    logic [cds_pkg::CFG_DATA_W-1:0]      i_cfg_data   = '0;
    logic                                i_valid      = 1'b0;
    logic signed [cds_pkg::SAMPLE_W-1:0] i_sample     = '0;
    logic                                i_line_first = 1'b0;
    logic                                i_stall      = 1'b0;
    logic                                o_stall;
    logic                                o_valid;
    logic signed [cds_pkg::SAMPLE_W-1:0] o_derivative;
    logic                                o_saturated;

    always #(PERIOD / 2) i_clk = ~i_clk;

    central_difference_stencil_core #(
        .MAX_TAPS (NUM_TAPS),
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_line_first(i_line_first),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_derivative(o_derivative),
        .o_saturated (o_saturated)
    );

    // Stencil state as the block should hold it. Entry 0 of the window is the
    // newest sample.
    logic signed [cds_pkg::SAMPLE_W-1:0] win  [NUM_TAPS];
    logic signed [cds_pkg::SAMPLE_W-1:0] taps [NUM_TAPS];
    logic [cds_pkg::HW_W-1:0]            hw_reg = cds_pkg::HALF_WIDTH_RESET;
    int                                  fill   = 0;

    t_deriv    pending_derivs [$];
    t_stim_row directed_rows  [$];

    int fail_count   = 0;
    int quiet_cycles = 0;
    int rx_wait      = 0;
    int line_left    = 0;
    int sample_style = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;

    // Published central-difference weights, scaled to integers. Row h-1 holds
    // the half width h set; the divisor turns them back into the true weights.
    int d1_num [21] = '{-1, 0, 1, 0, 0, 0, 0,
                         1, -8, 0, 8, -1, 0, 0,
                        -1, 9, -45, 0, 45, -9, 1};
    int d1_den [3]  = '{2, 12, 60};
    int d2_num [21] = '{1, -2, 1, 0, 0, 0, 0,
                        -1, 16, -30, 16, -1, 0, 0,
                         2, -27, 270, -490, 270, -27, 2};
    int d2_den [3]  = '{1, 12, 180};

    initial begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            win[k]  = '0;
            taps[k] = '0;
        end
    end

    // Shifts one sample into the window and, when the line holds enough
    // samples for the current width, works out the rounded, clamped sum.
    // The sum is kept exactly in 72 bits: seven products of 64 bits fit with
    // room to spare, even when every product is (-2^31)^2.
    function automatic bit stencil_step(input logic signed [cds_pkg::SAMPLE_W-1:0] s,
                                        input logic lf, output t_deriv d);
        logic signed [71:0] acc;
        int                 hw;
        int                 n;
        d.derivative = '0;
        d.saturated  = 1'b0;
        if (lf)
            fill = 0;
        for (int i = NUM_TAPS - 1; i > 0; i--)
            win[i] = win[i-1];
        win[0] = s;
        if (fill < NUM_TAPS)
            fill++;
        // A width of zero acts as one; anything past the window is clamped.
        hw = (hw_reg == 0) ? 1 : int'(hw_reg);
        if (hw > (NUM_TAPS - 1) / 2)
            hw = (NUM_TAPS - 1) / 2;
        n = 2 * hw + 1;
        if (fill < n)
            return 1'b0;
        // Round to nearest with ties upward: add half an LSB, then floor.
        acc = 72'sd1 <<< (FRAC - 1);
        for (int i = 0; i < n; i++)
            acc = acc + win[n-1-i] * taps[i];
        acc = acc >>> FRAC;
        if (acc > cds_pkg::OUT_MAX) begin
            d.derivative = cds_pkg::OUT_MAX;
            d.saturated  = 1'b1;
        end else if (acc < cds_pkg::OUT_MIN) begin
            d.derivative = cds_pkg::OUT_MIN;
            d.saturated  = 1'b1;
        end else begin
            d.derivative = acc[cds_pkg::SAMPLE_W-1:0];
        end
        return 1'b1;
    endfunction

    function automatic void add_word(input logic [31:0] s, input logic lf);
        t_stim_row r;
        r.kind       = ROW_WORD;
        r.idx        = cds_pkg::CFG_HALF_WIDTH;
        r.value      = s;
        r.line_first = lf;
        r.typed      = 1'b0;
        r.result.derivative = '0;
        r.result.saturated  = 1'b0;
        directed_rows.push_back(r);
    endfunction

    // A sample word whose derivative word is known by inspection.
    function automatic void add_check(input logic [31:0] s, input logic lf,
                                      input logic [31:0] deriv, input logic sat);
        t_stim_row r;
        r.kind       = ROW_WORD;
        r.idx        = cds_pkg::CFG_HALF_WIDTH;
        r.value      = s;
        r.line_first = lf;
        r.typed      = 1'b1;
        r.result.derivative = deriv;
        r.result.saturated  = sat;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_reg(input logic [cds_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] val);
        t_stim_row r;
        r.kind       = ROW_CFG;
        r.idx        = idx;
        r.value      = val;
        r.line_first = 1'b0;
        r.typed      = 1'b0;
        r.result.derivative = '0;
        r.result.saturated  = 1'b0;
        directed_rows.push_back(r);
    endfunction

    // Register writes leave the write enable high; close_cfg drops it once the
    // group of writes is done. The predictor takes the new value at once,
    // since writes only happen while nothing is in flight.
    task automatic write_reg(input logic [cds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        if (idx == cds_pkg::CFG_HALF_WIDTH)
            hw_reg = val[cds_pkg::HW_W-1:0];
        else
            taps[idx - cds_pkg::CFG_TAP_BASE] = val;
    endtask

    task automatic close_cfg();
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Drops valid, waits for every expected derivative word, then lets the
    // pipeline settle, since the last samples may have yielded nothing.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_derivs.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_SETTLE) @(negedge i_clk);
    endtask

    // Offers one sample word after a random gap and holds it until taken.
    // Valid stays high after acceptance; the next call or wait_idle moves it.
    task automatic send_word(input logic signed [cds_pkg::SAMPLE_W-1:0] s, input logic lf,
                             input bit typed, input t_deriv typed_res);
        int     gap;
        t_deriv d;
        gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_sample     = s;
        i_line_first = lf;
        do @(posedge i_clk); while (o_stall);
        if (stencil_step(s, lf, d))
            pending_derivs.push_back(typed ? typed_res : d);
    endtask

    // One random phase: a fresh width, usually a fresh tap set, then words in
    // lines of random length. A line may carry over from the previous phase,
    // which is how widths and taps change in the middle of a line.
    task automatic run_phase(input int words);
        logic [cds_pkg::HW_W-1:0]            hw_val;
        int                                  hw_eff;
        int                                  flavor;
        int                                  scale;
        longint                              w;
        logic signed [cds_pkg::SAMPLE_W-1:0] s;
        logic                                lf;
        t_deriv                              unused;
        unused.derivative = '0;
        unused.saturated  = 1'b0;
        wait_idle();
        hw_val = cds_pkg::HW_W'($urandom_range(0, 3));
        hw_eff = (hw_val == 0) ? 1 : int'(hw_val);
        write_reg(cds_pkg::CFG_HALF_WIDTH, 32'(hw_val));
        if ($urandom_range(0, 3) != 0) begin
            flavor = $urandom_range(0, 3);
            scale  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096)
                                                  : $urandom_range(1, 16);
            for (int k = 0; k < NUM_TAPS; k++) begin
                w = $urandom;
                // Taps past the active width keep random junk; they must not count.
                if (k < 2 * hw_eff + 1) begin
                    case (flavor)
                        0: w = longint'(d1_num[(hw_eff-1)*NUM_TAPS+k]) * longint'(Q_ONE)
                               * scale / d1_den[hw_eff-1];
                        1: w = longint'(d2_num[(hw_eff-1)*NUM_TAPS+k]) * longint'(Q_ONE)
                               * scale / d2_den[hw_eff-1];
                        3: begin
                            case ($urandom_range(0, 4))
                                0: w = cds_pkg::OUT_MAX;
                                1: w = cds_pkg::OUT_MIN;
                                2: w = 0;
                                3: w = Q_ONE;
                                default: w = -longint'(Q_ONE);
                            endcase
                        end
                        default: ;
                    endcase
                end
                write_reg(cds_pkg::CFG_TAP_BASE + cds_pkg::CFG_IDX_W'(k), w[31:0]);
            end
        end
        close_cfg();
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on = ($urandom_range(0, 2) != 0);
        repeat (words) begin
            if (line_left == 0) begin
                // Mostly full lines; a few too short to ever fill the window.
                line_left    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6)
                                                           : $urandom_range(7, 40);
                sample_style = $urandom_range(0, 2);
                lf = 1'b1;
            end else begin
                lf = 1'b0;
            end
            line_left--;
            case (sample_style)
                0: s = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
                1: s = $urandom;
                default: begin
                    case ($urandom_range(0, 4))
                        0: s = cds_pkg::OUT_MAX;
                        1: s = cds_pkg::OUT_MIN;
                        2: s = '0;
                        3: s = -1;
                        default: s = $urandom;
                    endcase
                end
            endcase
            send_word(s, lf, 1'b0, unused);
        end
    endtask

    // Receiver side: after each derivative word taken, stall a random while.
    always @(negedge i_clk) begin
        if (rx_wait > 0) begin
            i_stall = 1'b1;
            rx_wait--;
        end else begin
            i_stall = 1'b0;
        end
    end

    // Compares each derivative word with the oldest expectation and watches
    // for a stretch with no word moving on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_derivs.size() == 0) begin
                    fail_count++;
                    $error("derivative word %0d arrived with none expected", o_derivative);
                end else begin
                    if (o_derivative !== pending_derivs[0].derivative) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $error("derivative: expected %0d, got %0d",
                                   pending_derivs[0].derivative, o_derivative);
                    end
                    if (o_saturated !== pending_derivs[0].saturated) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $error("saturated: expected %0b, got %0b",
                                   pending_derivs[0].saturated, o_saturated);
                    end
                    void'(pending_derivs.pop_front());
                end
                rx_wait = rx_idle_on ? $urandom_range(0, 6) : 0;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        bit in_cfg;
        in_cfg = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Taps are zero after reset, so the first full window gives zero.
        add_word(cds_pkg::OUT_MAX, 1'b1);
        add_word(cds_pkg::OUT_MIN, 1'b0);
        add_check(32'd5, 1'b0, 32'd0, 1'b0);
        // First derivative, unit spacing: weights -1/2, 0, +1/2.
        add_reg(cds_pkg::CFG_TAP_BASE, Q_HALF_NEG);
        add_reg(cds_pkg::CFG_TAP_BASE + 3'd2, Q_HALF);
        add_word(Q_ONE, 1'b1);
        add_word(2 * Q_ONE, 1'b0);
        add_check(3 * Q_ONE, 1'b0, Q_ONE, 1'b0);
        add_word(cds_pkg::OUT_MAX, 1'b0);
        // A new line must refill; values in LSBs hit exact halves, which
        // round upward on both signs.
        add_word(32'd0, 1'b1);
        add_word(32'd1, 1'b0);
        add_check(32'd3, 1'b0, 32'd2, 1'b0);
        add_check(32'd0, 1'b0, 32'd0, 1'b0);
        add_check(-32'sd3, 1'b0, -32'sd3, 1'b0);
        // Width zero behaves as width one, in the middle of the line.
        add_reg(cds_pkg::CFG_HALF_WIDTH, 32'd0);
        add_check(32'd4, 1'b0, 32'd2, 1'b0);
        // Largest taps: clamp at both ends of the range.
        add_reg(cds_pkg::CFG_HALF_WIDTH, 32'd1);
        add_reg(cds_pkg::CFG_TAP_BASE, cds_pkg::OUT_MAX);
        add_reg(cds_pkg::CFG_TAP_BASE + 3'd1, cds_pkg::OUT_MAX);
        add_reg(cds_pkg::CFG_TAP_BASE + 3'd2, cds_pkg::OUT_MAX);
        add_word(cds_pkg::OUT_MAX, 1'b1);
        add_word(cds_pkg::OUT_MAX, 1'b0);
        add_check(cds_pkg::OUT_MAX, 1'b0, cds_pkg::OUT_MAX, 1'b1);
        add_word(cds_pkg::OUT_MIN, 1'b0);
        add_word(cds_pkg::OUT_MIN, 1'b0);
        add_check(cds_pkg::OUT_MIN, 1'b0, cds_pkg::OUT_MIN, 1'b1);
        // Widest window with the most negative taps and samples: seven
        // products of 2^62 need the full accumulator. The width grows mid-line.
        for (int k = 0; k < NUM_TAPS; k++)
            add_reg(cds_pkg::CFG_TAP_BASE + cds_pkg::CFG_IDX_W'(k), cds_pkg::OUT_MIN);
        add_reg(cds_pkg::CFG_HALF_WIDTH, 32'd3);
        add_word(cds_pkg::OUT_MIN, 1'b0);
        add_word(cds_pkg::OUT_MIN, 1'b0);
        add_word(cds_pkg::OUT_MIN, 1'b0);
        add_check(cds_pkg::OUT_MIN, 1'b0, cds_pkg::OUT_MAX, 1'b1);
        // Shrinking the width mid-line yields a word straight away.
        add_reg(cds_pkg::CFG_HALF_WIDTH, 32'd2);
        add_word(cds_pkg::OUT_MAX, 1'b0);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                if (!in_cfg) begin
                    wait_idle();
                    in_cfg = 1'b1;
                end
                write_reg(directed_rows[r].idx, directed_rows[r].value);
            end else begin
                if (in_cfg) begin
                    close_cfg();
                    in_cfg = 1'b0;
                end
                send_word(directed_rows[r].value, directed_rows[r].line_first,
                          directed_rows[r].typed, directed_rows[r].result);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(PHASE_WORDS);

        wait_idle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/cds_pkg.sv
hdl/cds_cell.sv
hdl/cds_add_stage.sv
hdl/central_difference_stencil_core.sv
tb/sv/testbench.sv
